@@ hdl/vtp_pkg.sv @@
// Shared types and constants for the vertex transform core.
// Used by vtp_mac, vertex_transform_perspective_core and the bench; no dependencies.
package vtp_pkg;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_XFORM = 2'd1;
   localparam logic [1:0] KIND_PERSP = 2'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         row;
      logic [1:0]         col;
      logic signed [31:0] coefficient;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               zero_w;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic       first;
      logic       last;
      logic [1:0] row;
   } mac_tag_type;

   typedef struct packed {
      logic       done;
      logic [1:0] row;
   } mac_stat_type;

   function automatic logic [31:0] mag32(logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

@@ hdl/vtp_mac.sv @@
// Shared multiply-accumulate unit: registered 32x32 product, floor shift, row sum.
// Depends on vtp_pkg.
module vtp_mac #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   input  vtp_pkg::mac_tag_type        op_tag,
   input  logic signed [31:0]          op_a,
   input  logic signed [31:0]          op_b,
   output logic signed [65-FRAC_BITS:0] acc,
   output vtp_pkg::mac_stat_type       stat
);

   localparam int ACC_W = 66 - FRAC_BITS;

   logic signed [63:0]      prod_ff;
   logic                    pvalid_ff;
   vtp_pkg::mac_tag_type    ptag_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   vtp_pkg::mac_stat_type   stat_ff, stat_in;
   logic signed [63:0]      shifted;
   logic signed [ACC_W-1:0] base;

   always_comb begin
      shifted = prod_ff >>> FRAC_BITS;
      base    = ptag_ff.first ? '0 : acc_ff;
      acc_in  = acc_ff;
      stat_in = '0;
      if (pvalid_ff) begin
         acc_in       = base + $signed(shifted[ACC_W-1:0]);
         stat_in.done = ptag_ff.last;
         stat_in.row  = ptag_ff.row;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
      ptag_ff <= op_tag;
      acc_ff  <= acc_in;
      if (reset) begin
         pvalid_ff <= 1'b0;
         stat_ff   <= '0;
      end else begin
         pvalid_ff <= op_valid;
         stat_ff   <= stat_in;
      end
   end

   assign acc  = acc_ff;
   assign stat = stat_ff;

endmodule

@@ hdl/vtp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Does not depend on vtp_pkg; no package items used here.
module vtp_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    div_start,
   input  logic [31+FRAC_BITS:0]   dividend,
   input  logic [31:0]             divisor,
   output logic                    div_done,
   output logic [31+FRAC_BITS:0]   quotient
);

   localparam int DVD_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic [32:0]      shifted;
   logic [33:0]      diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(DVD_W - 1);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (!diff[33]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/vertex_transform_perspective_core.sv @@
// 4x4 fixed-point vertex transform with optional perspective divide.
// Matrix write: taken while idle, busy stays low. Transform: 16 products through one shared
// multiplier, then drain and clamp; the response is registered, and a new transfer is taken
// once busy falls. Divide: three sequential divides, one quotient bit per cycle.
// Synchronous reset clears the matrix to zero and idles the sequencer.
// Depends on vtp_pkg, vtp_mac and vtp_div.
module vertex_transform_perspective_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vtp_pkg::req_type req_data,
   output logic             rsp_valid,
   output vtp_pkg::rsp_type rsp_data
);

   localparam int ACC_W = 66 - FRAC_BITS;
   localparam int DVD_W = 32 + FRAC_BITS;
   localparam logic [31:0] W_ONE = 32'd1 << FRAC_BITS;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL      = 3'd1;
   localparam logic [2:0] ST_DRAIN    = 3'd2;
   localparam logic [2:0] ST_DECIDE   = 3'd3;
   localparam logic [2:0] ST_DIV_GO   = 3'd4;
   localparam logic [2:0] ST_DIV_WAIT = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [1:0]         kind_ff, kind_in;
   logic [1:0]         comp_ff, comp_in;
   logic               sat_ff, sat_in;
   logic signed [31:0] matrix_ff [16];
   logic signed [31:0] matrix_in [16];
   logic signed [31:0] vec_ff [4];
   logic signed [31:0] vec_in [4];
   logic signed [31:0] res_ff [4];
   logic signed [31:0] res_in [4];
   vtp_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic                    mac_valid;
   vtp_pkg::mac_tag_type    mac_tag;
   logic signed [ACC_W-1:0] mac_acc;
   vtp_pkg::mac_stat_type   mac_stat;
   logic [ACC_W-32:0]       acc_hi;
   logic                    acc_ovf;
   logic signed [31:0]      acc_clamp;

   logic               div_start;
   logic [DVD_W-1:0]   div_dvd;
   logic [31:0]        div_dvs;
   logic               div_done;
   logic [DVD_W-1:0]   div_quot;
   logic               q_neg;
   logic               q_ovf;
   logic signed [31:0] q_val;

   vtp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .op_valid (mac_valid),
      .op_tag   (mac_tag),
      .op_a     (matrix_ff[cnt_ff]),
      .op_b     (vec_ff[cnt_ff[1:0]]),
      .acc      (mac_acc),
      .stat     (mac_stat)
   );

   vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .div_done  (div_done),
      .quotient  (div_quot)
   );

   always_comb begin
      accept        = start && !busy;
      mac_tag.first = (cnt_ff[1:0] == 2'd0);
      mac_tag.last  = (cnt_ff[1:0] == 2'd3);
      mac_tag.row   = cnt_ff[3:2];

      acc_hi    = mac_acc[ACC_W-1:31];
      acc_ovf   = !(&acc_hi) && (|acc_hi);
      acc_clamp = acc_ovf ? (mac_acc[ACC_W-1] ? vtp_pkg::S32_MIN : vtp_pkg::S32_MAX)
                          : mac_acc[31:0];

      div_dvd = {vtp_pkg::mag32(res_ff[comp_ff]), {FRAC_BITS{1'b0}}};
      div_dvs = vtp_pkg::mag32(res_ff[3]);
      q_neg   = res_ff[comp_ff][31] ^ res_ff[3][31];
      if (q_neg) begin
         q_ovf = (|div_quot[DVD_W-1:32]) || (div_quot[31] && (|div_quot[30:0]));
         q_val = q_ovf ? vtp_pkg::S32_MIN : $signed(~div_quot[31:0] + 32'd1);
      end else begin
         q_ovf = |div_quot[DVD_W-1:31];
         q_val = q_ovf ? vtp_pkg::S32_MAX : $signed(div_quot[31:0]);
      end

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      comp_in      = comp_ff;
      sat_in       = sat_ff;
      matrix_in    = matrix_ff;
      vec_in       = vec_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mac_valid    = 1'b0;
      div_start    = 1'b0;

      if (mac_stat.done) begin
         res_in[mac_stat.row] = acc_clamp;
         if (acc_ovf) sat_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  vtp_pkg::KIND_WRITE: begin
                     matrix_in[{req_data.row, req_data.col}] = req_data.coefficient;
                  end
                  vtp_pkg::KIND_XFORM, vtp_pkg::KIND_PERSP: begin
                     kind_in   = req_data.kind;
                     vec_in[0] = req_data.in_x;
                     vec_in[1] = req_data.in_y;
                     vec_in[2] = req_data.in_z;
                     vec_in[3] = req_data.in_w;
                     cnt_in    = '0;
                     sat_in    = 1'b0;
                     state_in  = ST_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            mac_valid = 1'b1;
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (mac_stat.done && mac_stat.row == 2'd3) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (kind_ff == vtp_pkg::KIND_XFORM) begin
               rsp_in.out_x     = res_ff[0];
               rsp_in.out_y     = res_ff[1];
               rsp_in.out_z     = res_ff[2];
               rsp_in.out_w     = res_ff[3];
               rsp_in.zero_w    = 1'b0;
               rsp_in.saturated = sat_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end else if (res_ff[3] == '0) begin
               rsp_in.out_x = res_ff[0] == '0 ? '0
                            : (res_ff[0][31] ? vtp_pkg::S32_MIN : vtp_pkg::S32_MAX);
               rsp_in.out_y = res_ff[1] == '0 ? '0
                            : (res_ff[1][31] ? vtp_pkg::S32_MIN : vtp_pkg::S32_MAX);
               rsp_in.out_z = res_ff[2] == '0 ? '0
                            : (res_ff[2][31] ? vtp_pkg::S32_MIN : vtp_pkg::S32_MAX);
               rsp_in.out_w     = '0;
               rsp_in.zero_w    = 1'b1;
               rsp_in.saturated = sat_ff || (res_ff[0] != '0) || (res_ff[1] != '0)
                                  || (res_ff[2] != '0);
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               comp_in  = 2'd0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_in[comp_ff] = q_val;
               if (q_ovf) sat_in = 1'b1;
               if (comp_ff == 2'd2) begin
                  rsp_in.out_x     = res_in[0];
                  rsp_in.out_y     = res_in[1];
                  rsp_in.out_z     = res_in[2];
                  rsp_in.out_w     = W_ONE;
                  rsp_in.zero_w    = 1'b0;
                  rsp_in.saturated = sat_ff || q_ovf;
                  rsp_valid_in     = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      kind_ff <= kind_in;
      comp_ff <= comp_in;
      sat_ff  <= sat_in;
      vec_ff  <= vec_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) matrix_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         matrix_ff    <= matrix_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/tb_vertex_transform_perspective_core.sv @@
// Self-checking bench for vertex_transform_perspective_core: matrix writes, transforms,
// and perspective divides, checked field by field against an in-bench fixed-point predictor.
// Depends on vtp_pkg and the core RTL.
module tb_vertex_transform_perspective_core;

   localparam int         FRAC_BITS      = 16;
   localparam int         ITEM_COUNT     = 1200;
   localparam int         QUIET_TAIL     = 100;
   localparam int         DRAIN_CYCLES   = 200;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] KIND_UNUSED    = 2'd3;
   localparam logic signed [31:0] ONE    = 32'sh0001_0000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   vtp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   vtp_pkg::rsp_type rsp_data;

   vtp_pkg::req_type   pending_requests[$];
   vtp_pkg::rsp_type   expected_vertices[$];
   logic signed [31:0] matrix_copy [16] = '{default: '0};
   vtp_pkg::rsp_type   wanted_vertex;
   int                 error_count     = 0;
   int                 checked_results = 0;
   int                 idle_left       = 0;
   int                 stall_cycles    = 0;
   bit                 bursty          = 1'b1;

   vertex_transform_perspective_core #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic field_check(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("result %0d %s got %h want %h",
                                 checked_results, name, got, want));
      end
   endtask

   function automatic logic signed [31:0] clamp_s32(input longint v, inout logic clipped);
      if (v > longint'(vtp_pkg::S32_MAX)) begin
         clipped = 1'b1;
         return vtp_pkg::S32_MAX;
      end
      if (v < longint'(vtp_pkg::S32_MIN)) begin
         clipped = 1'b1;
         return vtp_pkg::S32_MIN;
      end
      return v[31:0];
   endfunction

   function automatic void transform_vertex(input vtp_pkg::req_type item);
      longint           vec [4];
      longint           res [4];
      longint           acc;
      logic             clipped;
      vtp_pkg::rsp_type v;
      clipped = 1'b0;
      v = '0;
      if (item.kind == vtp_pkg::KIND_WRITE) begin
         matrix_copy[{item.row, item.col}] = item.coefficient;
      end else if (item.kind != KIND_UNUSED) begin
         vec[0] = longint'(item.in_x);
         vec[1] = longint'(item.in_y);
         vec[2] = longint'(item.in_z);
         vec[3] = longint'(item.in_w);
         for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
               acc += (longint'(matrix_copy[i*4+j]) * vec[j]) >>> FRAC_BITS;
            end
            res[i] = longint'(clamp_s32(acc, clipped));
         end
         if (item.kind == vtp_pkg::KIND_PERSP) begin
            if (res[3] == 0) begin
               v.zero_w = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  if (res[i] > 0) begin
                     res[i] = longint'(vtp_pkg::S32_MAX);
                     clipped = 1'b1;
                  end else if (res[i] < 0) begin
                     res[i] = longint'(vtp_pkg::S32_MIN);
                     clipped = 1'b1;
                  end
               end
               res[3] = 0;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  res[i] = longint'(clamp_s32((res[i] * (longint'(1) <<< FRAC_BITS)) /
                                              res[3], clipped));
               end
               res[3] = longint'(1) <<< FRAC_BITS;
            end
         end
         v.out_x     = res[0][31:0];
         v.out_y     = res[1][31:0];
         v.out_z     = res[2][31:0];
         v.out_w     = res[3][31:0];
         v.saturated = clipped;
         expected_vertices.push_back(v);
      end
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sd0;
         1: begin
            case ($urandom_range(0, 5))
               0: return vtp_pkg::S32_MAX;
               1: return vtp_pkg::S32_MIN;
               2: return -32'sd1;
               3: return 32'sd1;
               4: return ONE;
               default: return -ONE;
            endcase
         end
         2, 3: return $urandom;
         4, 5, 6: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      endcase
   endfunction

   function automatic void add_write(input int r, input int c, input logic [31:0] value);
      vtp_pkg::req_type item;
      item             = '0;
      item.kind        = vtp_pkg::KIND_WRITE;
      item.row         = r[1:0];
      item.col         = c[1:0];
      item.coefficient = value;
      item.in_x        = $urandom;
      item.in_y        = $urandom;
      item.in_z        = $urandom;
      item.in_w        = $urandom;
      pending_requests.push_back(item);
   endfunction

   function automatic void add_vertex(input logic [1:0] kind, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z,
                                      input logic [31:0] w);
      vtp_pkg::req_type item;
      item             = '0;
      item.kind        = kind;
      item.row         = 2'($urandom_range(0, 3));
      item.col         = 2'($urandom_range(0, 3));
      item.coefficient = $urandom;
      item.in_x        = x;
      item.in_y        = y;
      item.in_z        = z;
      item.in_w        = w;
      pending_requests.push_back(item);
   endfunction

   // driver: hold while busy, predict on transfer, then present next or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            transform_vertex(req_data);
         end
         if ($urandom_range(0, 39) == 0) begin
            bursty = !bursty;
         end
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            start <= 1'b0;
         end else if (bursty && pending_requests.size() > QUIET_TAIL &&
                      $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 16) - 1;
            start <= 1'b0;
         end else begin
            req_data <= pending_requests.pop_front();
            start    <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_vertices.size() == 0) begin
            flag_mismatch($sformatf("unexpected result x=%h y=%h z=%h w=%h",
                                    rsp_data.out_x, rsp_data.out_y,
                                    rsp_data.out_z, rsp_data.out_w));
         end else begin
            wanted_vertex = expected_vertices.pop_front();
            field_check("out_x", rsp_data.out_x, wanted_vertex.out_x);
            field_check("out_y", rsp_data.out_y, wanted_vertex.out_y);
            field_check("out_z", rsp_data.out_z, wanted_vertex.out_z);
            field_check("out_w", rsp_data.out_w, wanted_vertex.out_w);
            field_check("zero_w", 32'(rsp_data.zero_w), 32'(wanted_vertex.zero_w));
            field_check("saturated", 32'(rsp_data.saturated), 32'(wanted_vertex.saturated));
         end
         checked_results++;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("tb_vertex_transform_perspective_core: done, errors");
      $finish;
   end

   initial begin
      int counted;
      int sel;
      counted = 0;
      // zero matrix: plain transform, then divide by a zero w with zero numerators
      add_vertex(vtp_pkg::KIND_XFORM, $urandom, $urandom, $urandom, $urandom);
      add_vertex(vtp_pkg::KIND_PERSP, $urandom, $urandom, $urandom, $urandom);
      add_vertex(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < 4; i++) begin
         add_write(i, i, ONE);
      end
      add_vertex(vtp_pkg::KIND_XFORM, vtp_pkg::S32_MAX, vtp_pkg::S32_MIN, -32'sd1, 32'sd1);
      add_vertex(vtp_pkg::KIND_PERSP, vtp_pkg::S32_MAX, vtp_pkg::S32_MIN, 32'sh0003_0000,
                 ONE);
      add_vertex(vtp_pkg::KIND_PERSP, 32'sh0003_0000, -32'sh0005_0000, 32'sd7,
                 -32'sh0002_0000);
      add_vertex(vtp_pkg::KIND_PERSP, 32'sd5, -32'sd7, 32'sd0, 32'sd0);
      add_write(0, 0, 32'sh0000_8000);
      add_vertex(vtp_pkg::KIND_XFORM, -32'sd1, 32'sd3, -32'sd3, -ONE);
      add_write(0, 0, vtp_pkg::S32_MAX);
      add_write(0, 1, vtp_pkg::S32_MAX);
      add_vertex(vtp_pkg::KIND_XFORM, vtp_pkg::S32_MAX, vtp_pkg::S32_MAX, 32'sd0, ONE);
      add_write(0, 1, vtp_pkg::S32_MIN);
      add_vertex(vtp_pkg::KIND_XFORM, vtp_pkg::S32_MIN, vtp_pkg::S32_MAX, 32'sd0, ONE);
      add_write(3, 3, 32'sd1);
      add_vertex(vtp_pkg::KIND_PERSP, ONE, -ONE, 32'sd0, ONE);
      add_vertex(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_write(3, 2, vtp_pkg::S32_MIN);

      while (counted < ITEM_COUNT) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            add_vertex(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 5) begin
            add_write($urandom_range(0, 3), $urandom_range(0, 3), pick_value());
            counted++;
         end else if (sel == 5) begin
            // reload the whole matrix, sometimes with zero entries in the w row
            for (int i = 0; i < 16; i++) begin
               add_write(i / 4, i % 4, (i >= 12 && $urandom_range(0, 3) == 0) ?
                         32'sd0 : pick_value());
            end
            counted += 16;
         end else begin
            add_vertex($urandom_range(0, 1) ? vtp_pkg::KIND_PERSP : vtp_pkg::KIND_XFORM,
                       pick_value(), pick_value(), pick_value(), pick_value());
            counted++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_requests.size() != 0 || start || expected_vertices.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_vertex_transform_perspective_core: done, clean");
      end else begin
         $display("tb_vertex_transform_perspective_core: done, errors");
      end
      $finish;
   end

endmodule
